>>> sv/max_heap_priority_queue_defines.svh
// Assertion macros for the max-heap priority queue.
// Used by the top level; expects clk and rst in scope at the point of use.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MHPQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MHPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
// No dependencies.
`default_nettype none

package mhpq_pkg;

  localparam int CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic REG_CAPACITY = 1'b0;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

endpackage

`default_nettype wire

>>> sv/max_heap_priority_queue.sv
// Binary max-heap priority queue over one synchronous memory with APB configuration.
// Depends on mhpq_pkg and max_heap_priority_queue_defines.svh.
//
// An operation is transferred at a clock edge with start high and busy low; its result is
// shown for one cycle with done high and cannot be held off. A refused operation, an insert
// into an empty heap and a delete that leaves the heap empty finish from idle, with done high
// in the cycle after the transfer. An insert reads the parent, then takes one S_UP step per
// level the value climbs (plus an S_PLACE write if it reaches the root); a delete reads the
// last entry in S_LOAD, then one S_DOWN step per level it descends. Heap reads are registered.
`default_nettype none

module max_heap_priority_queue #(
  parameter int HEAP_DEPTH  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 kind,
  input  wire logic signed [VALUE_WIDTH-1:0]        value,
  output logic                                      done,
  output logic [1:0]                                status,
  output logic signed [VALUE_WIDTH-1:0]             top_value,
  output logic                                      top_valid,
  output logic [$clog2(HEAP_DEPTH+1)-1:0]           entry_count,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [2:0]                           paddr,
  input  wire logic [31:0]                          pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH+1);
  localparam int IW = AW + 2;
  localparam int LW = (CW > mhpq_pkg::CAP_W) ? CW : mhpq_pkg::CAP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_UP,
    S_DOWN,
    S_PLACE
  } state_t;

  logic signed [VALUE_WIDTH-1:0] mem [HEAP_DEPTH];
  logic signed [VALUE_WIDTH-1:0] rd_a;
  logic signed [VALUE_WIDTH-1:0] rd_b;
  logic [AW-1:0]                 rd_addr_a;
  logic [AW-1:0]                 rd_addr_b;
  logic                          we;
  logic [AW-1:0]                 waddr;
  logic signed [VALUE_WIDTH-1:0] wdata;

  state_t                        state, state_next;
  logic [CW-1:0]                 count, count_next;
  logic [AW-1:0]                 idx, idx_next;
  logic signed [VALUE_WIDTH-1:0] hold, hold_next;
  logic signed [VALUE_WIDTH-1:0] root;
  mhpq_pkg::status_t             result_status, result_status_next;
  logic                          done_next;
  logic [mhpq_pkg::CAP_W-1:0]    capacity_limit;

  logic                          full;
  logic [CW-1:0]                 cnt_m1;
  logic [CW-1:0]                 cnt_half;
  logic [AW-1:0]                 idx_m1;
  logic [AW-1:0]                 par;
  logic [AW-1:0]                 par_m1;
  logic [AW-1:0]                 grand;
  logic [IW-1:0]                 left_i;
  logic [IW-1:0]                 right_i;
  logic [IW-1:0]                 count_ext;
  logic                          go_left;
  logic                          go_right;
  logic signed [VALUE_WIDTH-1:0] best_val;
  logic [AW-1:0]                 child;
  logic [IW-1:0]                 gc_left;
  logic [IW-1:0]                 gc_right;

  assign full = (LW'(count) >= LW'(capacity_limit)) || (LW'(count) >= LW'(HEAP_DEPTH));

  assign cnt_m1   = count - CW'(1);
  assign cnt_half = cnt_m1 >> 1;
  assign idx_m1   = idx - AW'(1);
  assign par      = idx_m1 >> 1;
  assign par_m1   = par - AW'(1);
  assign grand    = par_m1 >> 1;

  assign left_i    = {1'b0, idx, 1'b1};
  assign right_i   = left_i + IW'(1);
  assign count_ext = IW'(count);
  assign go_left   = (left_i < count_ext) && (hold < rd_a);
  assign best_val  = go_left ? rd_a : hold;
  assign go_right  = (right_i < count_ext) && (best_val < rd_b);
  assign child     = go_right ? right_i[AW-1:0] : left_i[AW-1:0];
  assign gc_left   = {1'b0, child, 1'b1};
  assign gc_right  = gc_left + IW'(1);

  always_comb begin
    state_next         = state;
    count_next         = count;
    idx_next           = idx;
    hold_next          = hold;
    result_status_next = result_status;
    done_next          = 1'b0;
    rd_addr_a          = '0;
    rd_addr_b          = '0;
    we                 = 1'b0;
    waddr              = idx;
    wdata              = hold;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (kind == mhpq_pkg::KIND_INSERT) begin
            if (full) begin
              result_status_next = mhpq_pkg::STATUS_FULL;
              done_next          = 1'b1;
            end else begin
              result_status_next = mhpq_pkg::STATUS_DONE;
              count_next         = count + CW'(1);
              hold_next          = value;
              idx_next           = count[AW-1:0];
              if (count == '0) begin
                we        = 1'b1;
                waddr     = '0;
                wdata     = value;
                done_next = 1'b1;
              end else begin
                rd_addr_a  = cnt_half[AW-1:0];
                state_next = S_UP;
              end
            end
          end else begin
            if (count == '0) begin
              result_status_next = mhpq_pkg::STATUS_EMPTY;
              done_next          = 1'b1;
            end else begin
              result_status_next = mhpq_pkg::STATUS_DONE;
              count_next         = cnt_m1;
              if (count == CW'(1)) begin
                done_next = 1'b1;
              end else begin
                rd_addr_a  = cnt_m1[AW-1:0];
                state_next = S_LOAD;
              end
            end
          end
        end
      end
      S_LOAD: begin
        hold_next  = rd_a;
        idx_next   = '0;
        rd_addr_a  = AW'(1);
        rd_addr_b  = AW'(2);
        state_next = S_DOWN;
      end
      S_UP: begin
        we = 1'b1;
        if (hold > rd_a) begin
          wdata    = rd_a;
          idx_next = par;
          if (par == '0) begin
            state_next = S_PLACE;
          end else begin
            rd_addr_a  = grand;
          end
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DOWN: begin
        we = 1'b1;
        if (go_left || go_right) begin
          wdata     = go_right ? rd_b : rd_a;
          idx_next  = child;
          rd_addr_a = gc_left[AW-1:0];
          rd_addr_b = gc_right[AW-1:0];
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_PLACE: begin
        we         = 1'b1;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    idx           <= idx_next;
    hold          <= hold_next;
    result_status <= result_status_next;
    if (we && waddr == '0) begin
      root <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= mhpq_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == mhpq_pkg::REG_CAPACITY) begin
      capacity_limit <= pwdata[mhpq_pkg::CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == mhpq_pkg::REG_CAPACITY) ? 32'(capacity_limit) : '0;
  assign pready = 1'b1;

  assign busy        = (state != S_IDLE);
  assign status      = result_status;
  assign top_valid   = (count != '0);
  assign top_value   = top_valid ? root : '0;
  assign entry_count = count;

`include "max_heap_priority_queue_defines.svh"

  `MHPQ_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "transfer lost")
  `MHPQ_ASSERT_SAME(a_count_bound, done, count <= CW'(HEAP_DEPTH), "count above depth")
  `MHPQ_ASSERT_SAME(a_full_keeps, done && result_status == mhpq_pkg::STATUS_FULL,
    $stable(count), "refused insert changed count")
  `MHPQ_ASSERT_SAME(a_empty_count, done && result_status == mhpq_pkg::STATUS_EMPTY,
    count == '0, "empty refusal with entries")

endmodule

`default_nettype wire
